@@ rtl/halton_radical_inverse_defines.svh @@
// Assertion macros for the radical inverse block
`ifndef HALTON_RADICAL_INVERSE_DEFINES_SVH
`define HALTON_RADICAL_INVERSE_DEFINES_SVH

`ifndef SYNTHESIS

`define HRI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define HRI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define HRI_ASSERT(lbl, prop, msg)

`define HRI_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

@@ rtl/hri_pkg.sv @@
package hri_pkg;

  localparam int IDX_W     = 31;
  localparam int FRAC_W    = 32;
  localparam int BASE_W    = 8;
  localparam int DIV_STEPS = 8;
  localparam int DIV_CYC   = (IDX_W + DIV_STEPS - 1) / DIV_STEPS;
  localparam int DIV_W     = DIV_CYC * DIV_STEPS;
  localparam int PW        = IDX_W + BASE_W;
  localparam int CNT_MAX   = (DIV_CYC > FRAC_W) ? DIV_CYC : FRAC_W;
  localparam int CNT_W     = $clog2(CNT_MAX);

  typedef struct packed {
    logic [IDX_W-1:0]  sample_index;
    logic [BASE_W-1:0] base;
  } hri_in_t;

  typedef struct packed {
    logic [FRAC_W-1:0] fraction;
    logic              bad_base;
  } hri_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOP,
    ST_DIV,
    ST_MUL_M,
    ST_MUL_P,
    ST_NORM,
    ST_DONE
  } hri_state_t;

  typedef struct packed {
    logic load;
    logic div_init;
    logic div_step;
    logic mul_m;
    logic mul_p;
    logic norm_init;
    logic norm_step;
    logic out_load;
  } hri_cmd_t;

  typedef struct packed {
    logic bad;
    logic idx_zero;
    logic div_last;
    logic norm_last;
    logic out_full;
  } hri_sts_t;

endpackage

@@ rtl/halton_radical_inverse.sv @@
// Channel | Ports                          | Payload
// --------+--------------------------------+-------------------------------
// input   | in_valid, in_stall, in_data    | sample_index[30:0], base[7:0]
// result  | out_valid, out_stall, out_data | fraction[31:0], bad_base
//
// One item at a time. Per base-b digit of the index: a loop check, the digit
// division (8 bits/cycle), then two passes of the shared multiplier; then the
// 32-step normalising divider, then the transfer into the output register.
// A bad base skips the digit loop and the divider and goes straight to the
// transfer. Synchronous active-low reset, idle after.
// A finished result waits in the output register under out_stall; the next
// item is taken meanwhile and parks before the output register until it frees.
module halton_radical_inverse
  import hri_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  hri_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output hri_out_t out_data
);

  hri_cmd_t cmd;
  hri_sts_t sts;

  hri_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  hri_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ rtl/hri_ctrl.sv @@
`include "halton_radical_inverse_defines.svh"

module hri_ctrl
  import hri_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output hri_cmd_t cmd,
  input  hri_sts_t sts
);

  hri_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_LOOP;
        end
      end
      ST_LOOP: begin
        if (sts.bad) begin
          state_nxt = ST_DONE;
        end else if (sts.idx_zero) begin
          cmd.norm_init = 1'b1;
          state_nxt     = ST_NORM;
        end else begin
          cmd.div_init = 1'b1;
          state_nxt    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_MUL_M;
        end
      end
      ST_MUL_M: begin
        cmd.mul_m = 1'b1;
        state_nxt = ST_MUL_P;
      end
      ST_MUL_P: begin
        cmd.mul_p = 1'b1;
        state_nxt = ST_LOOP;
      end
      ST_NORM: begin
        cmd.norm_step = 1'b1;
        if (sts.norm_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!sts.out_full) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  `HRI_ASSERT(a_accept_to_loop, (in_valid && !in_stall) |=> (state_r == ST_LOOP), "accept did not start digit loop")
  `HRI_ASSERT(a_div_to_mul, (state_r == ST_DIV && sts.div_last) |=> (state_r == ST_MUL_M), "digit division did not end in multiply")
  `HRI_ASSERT(a_norm_good_base, (state_r == ST_NORM) |-> !sts.bad, "normalising with a bad base")

endmodule

@@ rtl/hri_dpath.sv @@
`include "halton_radical_inverse_defines.svh"

module hri_dpath
  import hri_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  hri_cmd_t cmd,
  output hri_sts_t sts,
  input  hri_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output hri_out_t out_data
);

  logic [DIV_W-1:0]  idx_r;
  logic [BASE_W-1:0] base_r;
  logic [BASE_W-1:0] rem_r;
  logic [PW-1:0]     m_r;
  logic [PW-1:0]     p_r;
  logic [PW-1:0]     nr_r;
  logic [FRAC_W-1:0] q_r;
  logic              bad_r;
  logic [CNT_W-1:0]  cnt_r;
  hri_out_t          out_r;
  logic              out_full_r;

  // digit division, DIV_STEPS quotient bits per cycle
  logic [BASE_W-1:0] dr;
  logic [DIV_W-1:0]  dq;
  logic [BASE_W:0]   dt;

  always_comb begin
    dr = rem_r;
    dq = idx_r;
    dt = '0;
    for (int i = 0; i < DIV_STEPS; i++) begin
      dt = {dr, dq[DIV_W-1]};
      dq = {dq[DIV_W-2:0], 1'b0};
      if (dt >= {1'b0, base_r}) begin
        dt    = dt - {1'b0, base_r};
        dq[0] = 1'b1;
      end
      dr = dt[BASE_W-1:0];
    end
  end

  // shared multiplier: M = M*b + d, P = P*b
  logic [PW-1:0]        mul_a;
  logic [PW+BASE_W-1:0] prod;
  logic [PW-1:0]        addend;
  logic [PW-1:0]        mac;

  assign mul_a  = cmd.mul_m ? m_r : p_r;
  assign prod   = mul_a * base_r;
  assign addend = cmd.mul_m ? PW'(rem_r) : '0;
  assign mac    = prod[PW-1:0] + addend;

  // normalising division M * 2^FRAC_W / P, one bit per cycle
  logic [PW:0] nt;
  logic [PW:0] nd;
  logic        nge;

  assign nt  = {nr_r, 1'b0};
  assign nd  = nt - {1'b0, p_r};
  assign nge = nt >= {1'b0, p_r};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx_r  <= DIV_W'(in_data.sample_index);
      base_r <= in_data.base;
      bad_r  <= in_data.base < BASE_W'(2);
      m_r    <= '0;
      p_r    <= PW'(1);
      q_r    <= '0;
    end
    if (cmd.div_init) begin
      rem_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= dr;
      idx_r <= dq;
    end
    if (cmd.mul_m) begin
      m_r <= mac;
    end
    if (cmd.mul_p) begin
      p_r <= mac;
    end
    if (cmd.norm_init) begin
      nr_r <= m_r;
    end else if (cmd.norm_step) begin
      nr_r <= nge ? nd[PW-1:0] : nt[PW-1:0];
      q_r  <= {q_r[FRAC_W-2:0], nge};
    end
    if (cmd.div_init || cmd.norm_init) begin
      cnt_r <= '0;
    end else if (cmd.div_step || cmd.norm_step) begin
      cnt_r <= cnt_r + CNT_W'(1);
    end
    if (cmd.out_load) begin
      out_r.fraction <= q_r;
      out_r.bad_base <= bad_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_full_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_full_r <= 1'b1;
    end else if (out_full_r && !out_stall) begin
      out_full_r <= 1'b0;
    end
  end

  assign sts.bad       = bad_r;
  assign sts.idx_zero  = (idx_r == '0);
  assign sts.div_last  = (cnt_r == CNT_W'(DIV_CYC - 1));
  assign sts.norm_last = (cnt_r == CNT_W'(FRAC_W - 1));
  assign sts.out_full  = out_full_r;

  assign out_valid = out_full_r;
  assign out_data  = out_r;

  `HRI_ASSERT(a_bad_zero, (out_full_r && out_r.bad_base) |-> (out_r.fraction == '0), "bad base with nonzero fraction")
  `HRI_ASSERT(a_norm_rem, cmd.norm_step |-> (nr_r < p_r), "normalising remainder not below scale")

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import hri_pkg::*;

  localparam int RANDOM_PER_PHASE = 363;
  localparam int DRAIN_CYCLES     = 300;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  hri_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  hri_out_t out_data;

  hri_in_t  pending_q[$];
  hri_out_t inverse_q[$];
  logic     in_taken = 1'b0;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  int       transfers_in = 0;
  int       bad_base_items = 0;
  int       results_checked = 0;
  int       mismatch_count = 0;

  halton_radical_inverse DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #1 clk = ~clk;

  // digits taken least significant first, folded back in from the most significant
  function automatic hri_out_t radical_inverse(hri_in_t item);
    logic [IDX_W-1:0]  rest;
    logic [BASE_W-1:0] digit_q[$];
    logic [63:0]       acc;
    hri_out_t          res;
    res = '0;
    if (item.base < 2) begin
      res.bad_base = 1'b1;
      return res;
    end
    rest = item.sample_index;
    while (rest != 0) begin
      digit_q.push_back(BASE_W'(rest % item.base));
      rest = rest / item.base;
    end
    acc = '0;
    while (digit_q.size() != 0) begin
      acc = ((64'(digit_q.pop_back()) << FRAC_W) + acc) / item.base;
    end
    res.fraction = acc[FRAC_W-1:0];
    return res;
  endfunction

  task automatic add_item(input logic [IDX_W-1:0] idx, input logic [BASE_W-1:0] radix);
    hri_in_t item;
    item.sample_index = idx;
    item.base = radix;
    pending_q.push_back(item);
  endtask

  // input side: record accepted transfers at the rising edge
  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      inverse_q.push_back(radical_inverse(in_data));
      transfers_in++;
      if (in_data.base < 2) bad_base_items++;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data <= pending_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side
  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    hri_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_checked++;
      if (inverse_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result transfer: fraction %h bad_base %b",
                   out_data.fraction, out_data.bad_base);
      end else begin
        want = inverse_q.pop_front();
        if (out_data.fraction !== want.fraction || out_data.bad_base !== want.bad_base) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: fraction %h bad_base %b, expected %h %b",
                     out_data.fraction, out_data.bad_base, want.fraction, want.bad_base);
        end
      end
    end
  end

  initial begin
    logic [IDX_W-1:0]  idx;
    logic [BASE_W-1:0] radix;
    int                pick;
    add_item('0, 8'd2);
    add_item('0, 8'd255);
    add_item(31'd1, 8'd2);
    add_item(31'd2, 8'd2);
    add_item(31'd3, 8'd2);
    add_item(31'h7FFFFFFF, 8'd2);
    add_item(31'h7FFFFFFE, 8'd2);
    add_item(31'h40000000, 8'd2);
    add_item(31'h7FFFFFFF, 8'd3);
    add_item(31'h7FFFFFFF, 8'd254);
    add_item(31'h7FFFFFFF, 8'd255);
    add_item(31'd1, 8'd255);
    add_item(31'd254, 8'd255);
    add_item(31'd255, 8'd255);
    add_item(31'd100, 8'd10);
    add_item(31'h2AAAAAAA, 8'd16);
    add_item(31'h2AAAAAAA, 8'd7);
    add_item(31'h12345678, 8'd128);
    add_item('0, 8'd0);
    add_item(31'd5, 8'd0);
    add_item(31'h7FFFFFFF, 8'd0);
    add_item('0, 8'd1);
    add_item(31'd123, 8'd1);
    add_item(31'h7FFFFFFF, 8'd1);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
        default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        pick = $urandom_range(99);
        if (pick < 8) radix = BASE_W'($urandom_range(1));
        else if (pick < 35) radix = BASE_W'($urandom_range(4, 2));
        else radix = BASE_W'($urandom_range(255, 2));
        pick = $urandom_range(99);
        if (pick < 50) idx = IDX_W'($urandom);
        else if (pick < 70) idx = IDX_W'($urandom_range(1000));
        else if (pick < 85) idx = IDX_W'($urandom >> $urandom_range(31, 1));
        else idx = 31'h7FFFFFFF - IDX_W'($urandom_range(300));
        add_item(idx, radix);
      end
      while (pending_q.size() != 0 || in_valid || inverse_q.size() != 0) @(posedge clk);
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d transfers in, %0d results checked, %0d with a bad base", transfers_in,
             results_checked, bad_base_items);
    $display("four handshake phases: free running, sender gaps, receiver stalls, both");
    if (mismatch_count == 0 && inverse_q.size() == 0) begin
      $display("halton_radical_inverse test passed");
    end else begin
      $display("%0d mismatches, %0d results outstanding", mismatch_count, inverse_q.size());
      $display("halton_radical_inverse test failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", inverse_q.size());
    $display("halton_radical_inverse test failed");
    $finish;
  end

endmodule
